// ----- rtl/core/prsr_pkg.sv -----
// Shared types and constants for the slot range reserver.
`timescale 1ns / 1ps

package prsr_pkg;

	localparam int PREF_W      = 2;
	localparam int SLOT_W      = 8;
	localparam int WIN_IDX_W   = 2;
	localparam int PREF_FIELDS = 3;
	localparam int WIN_FIELDS  = 3;

	typedef struct packed {
		logic [SLOT_W-1:0] start;
		logic [SLOT_W-1:0] stop;
	} win_t;

	typedef struct packed {
		logic                 granted;
		logic [PREF_W-1:0]    resource;
		logic [WIN_IDX_W-1:0] window;
	} grant_t;

	typedef struct packed {
		logic                 mark;
		logic [WIN_IDX_W-1:0] window;
	} lane_ctl_t;

endpackage

// ----- rtl/core/prsr_lane.sv -----
// One resource lane: occupancy row, window fit checks and write-back of a reservation.
`timescale 1ns / 1ps

module prsr_lane
	import prsr_pkg::*;
#(
	parameter int SLOTS          = 144,
	parameter int WINDOW_CHOICES = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  win_t [WINDOW_CHOICES-1:0]       win,
	input  lane_ctl_t                       ctl,
	output logic [WINDOW_CHOICES-1:0]       fit
);

	localparam int IW = SLOT_W + 1;

	logic [SLOTS-1:0]                     row_q;
	logic [WINDOW_CHOICES-1:0][SLOTS-1:0] mask;
	logic [SLOTS-1:0]                     sel_mask;

	always_comb begin
		sel_mask = '0;
		for (int w = 0; w < WINDOW_CHOICES; w++) begin
			for (int s = 0; s < SLOTS; s++) begin
				mask[w][s] = ({1'b0, win[w].start} <= IW'(s)) && (IW'(s) < {1'b0, win[w].stop});
			end
			fit[w] = (win[w].start >= win[w].stop) ||
				(({1'b0, win[w].stop} <= IW'(SLOTS)) && ((row_q & mask[w]) == '0));
			if (ctl.window == WIN_IDX_W'(w)) begin
				sel_mask = mask[w];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.mark) begin
			row_q <= row_q | sel_mask;
		end
	end

endmodule

// ----- rtl/core/prsr_merge.sv -----
// Priority merge of the lane fit results over preferences and windows.
`timescale 1ns / 1ps

module prsr_merge
	import prsr_pkg::*;
#(
	parameter int RESOURCES        = 3,
	parameter int RESOURCE_CHOICES = 3,
	parameter int WINDOW_CHOICES   = 3
) (
	input  logic [PREF_FIELDS-1:0][PREF_W-1:0]       pref,
	input  logic [RESOURCES-1:0][WINDOW_CHOICES-1:0] fit,
	output grant_t                                   grant
);

	always_comb begin
		grant = '0;
		for (int p = 0; p < RESOURCE_CHOICES; p++) begin
			for (int w = 0; w < WINDOW_CHOICES; w++) begin
				for (int r = 0; r < RESOURCES; r++) begin
					if (!grant.granted && (pref[p] == PREF_W'(r)) && fit[r][w]) begin
						grant.granted  = 1'b1;
						grant.resource = PREF_W'(r);
						grant.window   = WIN_IDX_W'(w);
					end
				end
			end
		end
	end

endmodule

// ----- rtl/core/preference_slot_range_reserver_core.sv -----
// Top level of the slot range reserver: request register, resource lanes, merge and response register.
//
//   channel   direction  handshake              payload
//   request   in         req_valid / req_ready  venue_pref_0..2, win_start_0..2, win_end_0..2
//   response  out        rsp_valid / rsp_ready  granted, granted_resource, granted_window
//
// A request waits in the request register while all lanes check their windows and the merge picks
// the grant; when it resolves, the chosen lane marks its row and the response register loads.
// The response passes the request register and then the response register; a new request is
// taken every cycle unless a stalled response holds the request register.
// Reset clears every occupancy row at once; no clearing pass is needed.
// A stalled response holds the request register, and then no new request is taken.
`timescale 1ns / 1ps

module preference_slot_range_reserver_core
	import prsr_pkg::*;
#(
	parameter int RESOURCES        = 3,
	parameter int SLOTS            = 144,
	parameter int RESOURCE_CHOICES = 3,
	parameter int WINDOW_CHOICES   = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [PREF_W-1:0] venue_pref_0,
	input  logic [PREF_W-1:0] venue_pref_1,
	input  logic [PREF_W-1:0] venue_pref_2,
	input  logic [SLOT_W-1:0] win_start_0,
	input  logic [SLOT_W-1:0] win_end_0,
	input  logic [SLOT_W-1:0] win_start_1,
	input  logic [SLOT_W-1:0] win_end_1,
	input  logic [SLOT_W-1:0] win_start_2,
	input  logic [SLOT_W-1:0] win_end_2,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              granted,
	output logic [PREF_W-1:0] granted_resource,
	output logic [WIN_IDX_W-1:0] granted_window
);

	logic                                   valid_s1;
	logic [PREF_FIELDS-1:0][PREF_W-1:0]     pref_s1;
	win_t [WIN_FIELDS-1:0]                  win_s1;
	logic                                   fire;
	logic                                   accept;
	logic [RESOURCES-1:0][WINDOW_CHOICES-1:0] fit;
	grant_t                                 grant;
	grant_t                                 rsp_q;
	logic                                   rsp_valid_q;

	assign fire      = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || fire;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pref_s1      <= {venue_pref_2, venue_pref_1, venue_pref_0};
			win_s1[0]    <= '{start: win_start_0, stop: win_end_0};
			win_s1[1]    <= '{start: win_start_1, stop: win_end_1};
			win_s1[2]    <= '{start: win_start_2, stop: win_end_2};
		end
	end

	for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
		lane_ctl_t ctl;

		assign ctl = {fire && grant.granted && (grant.resource == PREF_W'(r)), grant.window};

		prsr_lane #(
			.SLOTS          (SLOTS),
			.WINDOW_CHOICES (WINDOW_CHOICES)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.win    (win_s1[WINDOW_CHOICES-1:0]),
			.ctl    (ctl),
			.fit    (fit[r])
		);
	end

	prsr_merge #(
		.RESOURCES        (RESOURCES),
		.RESOURCE_CHOICES (RESOURCE_CHOICES),
		.WINDOW_CHOICES   (WINDOW_CHOICES)
	) u_merge (
		.pref  (pref_s1),
		.fit   (fit),
		.grant (grant)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= grant;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign granted          = rsp_q.granted;
	assign granted_resource = rsp_q.resource;
	assign granted_window   = rsp_q.window;

	// A resolved request always shows up as a response at the next edge.
	a_fire_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("resolved request did not produce a response");

	// A failure reports zero resource and window.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !granted) |-> (granted_resource == '0 && granted_window == '0))
		else $error("failed response carries nonzero indexes");

	// A grant names an existing resource and window.
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && granted) |->
			(({1'b0, granted_resource} < 3'(RESOURCES)) &&
			 ({1'b0, granted_window} < 3'(WINDOW_CHOICES))))
		else $error("grant outside resource or window range");

	// The request register never loads while a request is still waiting to resolve.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |-> !req_ready)
		else $error("request register ready while holding an unresolved request");

endmodule
